>>> src/dnsqe_pkg.sv
// ----------------------------------------------------------------------------
// dnsqe_pkg
// Result codes, end status codes and result queue types for the DNS query
// name extractor.
// ----------------------------------------------------------------------------
package dnsqe_pkg;

  localparam logic [1:0] KIND_DETECT = 2'd0;
  localparam logic [1:0] KIND_CHAR   = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;

  localparam logic [1:0] END_ZERO    = 2'd0;
  localparam logic [1:0] END_PAYLOAD = 2'd1;
  localparam logic [1:0] END_CAP     = 2'd2;
  localparam logic [1:0] END_TRUNC   = 2'd3;

  localparam int OQ_DEPTH = 8;
  localparam int OQ_AW    = 3;
  localparam int OQ_CW    = 4;
  localparam logic [OQ_CW-1:0] OQ_LIMIT = 4'd4;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] name_char;
    logic [1:0] end_status;
    logic       run_last;
  } result_t;

  typedef struct packed {
    result_t     res;
    logic [31:0] dns_count;
    logic [31:0] source_addr;
    logic [31:0] dest_addr;
  } oq_entry_t;

endpackage

>>> src/dns_query_name_extractor_top.sv
// ----------------------------------------------------------------------------
// dns_query_name_extractor_top
// Parses IPv4/UDP headers byte by byte, detects DNS by port and walks the
// query name labels, emitting a detection, characters, dots and an end result.
// ----------------------------------------------------------------------------
//  channel | signals                          | transfer when
//  --------+----------------------------------+-------------------------
//  input   | in_valid in_stall pkt_*          | in_valid & !in_stall
//  output  | out_valid out_stall result_*...  | out_valid & !out_stall
//  config  | cfg_we cfg_wdata (dns_port)      | cfg_we
//
//  One byte is taken per cycle while in_stall is low; its first result passes
//  through the input register and the result queue before it is offered.
//  Each byte gives up to two results, one leaves per cycle while out_stall is
//  low, through an eight-entry result queue.
//  in_stall rises while the queue holds more than four entries.
//  Synchronous reset clears all parse state and sets dns_port to 53.
// ----------------------------------------------------------------------------
module dns_query_name_extractor_top
  import dnsqe_pkg::*;
#(
  parameter int NAME_BUFFER = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  pkt_byte,
  input  logic        pkt_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  result_kind,
  output logic [7:0]  name_char,
  output logic [1:0]  end_status,
  output logic [31:0] dns_count,
  output logic [31:0] source_addr,
  output logic [31:0] dest_addr,
  output logic        run_last
);

  localparam int NL_W = (NAME_BUFFER > 2) ? $clog2(NAME_BUFFER) : 1;
  localparam logic [NL_W-1:0] NAME_CAP = NL_W'(NAME_BUFFER - 1);

  localparam logic [2:0] PH_HEAD = 3'd0;
  localparam logic [2:0] PH_SKIP = 3'd2;
  localparam logic [2:0] PH_WALK = 3'd3;
  localparam logic [2:0] PH_DONE = 3'd4;

  logic [15:0]     dns_port;

  logic            s_valid;
  logic [7:0]      s_byte;
  logic            s_last;

  logic [15:0]     byte_offset, byte_offset_next;
  logic [3:0]      header_words, header_words_next;
  logic [31:0]     src_ip, src_ip_next;
  logic [31:0]     dst_ip, dst_ip_next;
  logic [15:0]     src_port_hold, src_port_hold_next;
  logic [15:0]     udp_length, udp_length_next;
  logic [31:0]     packet_counter, packet_counter_next;
  logic [2:0]      parse_phase, parse_phase_next;
  logic [7:0]      label_remaining, label_remaining_next;
  logic [NL_W-1:0] name_length, name_length_next;
  logic            port_hit, port_hit_next;

  logic [15:0]     hdr_len;
  logic [15:0]     name_span;
  logic [16:0]     label_reach;
  logic [16:0]     offset_inc;
  logic [15:0]     port_word;
  logic            port_match;
  logic            name_full;

  result_t         res_a, res_b;
  logic [1:0]      res_n;

  oq_entry_t       oq_mem [OQ_DEPTH];
  logic [OQ_AW-1:0] oq_wr, oq_rd;
  logic [OQ_CW-1:0] oq_count;
  logic            oq_pop;
  oq_entry_t       oq_head;

  function automatic result_t make_res(logic [1:0] kind, logic [7:0] ch, logic [1:0] st);
    result_t r;
    r.kind       = kind;
    r.name_char  = ch;
    r.end_status = st;
    r.run_last   = 1'b0;
    return r;
  endfunction

  assign in_stall    = oq_count > OQ_LIMIT;
  assign hdr_len     = {10'd0, header_words, 2'b00};
  assign name_span   = udp_length - 16'd20;
  assign label_reach = {1'b0, byte_offset} + {9'd0, s_byte};
  assign offset_inc  = {1'b0, byte_offset} + 17'd1;
  assign port_word   = {src_port_hold[7:0], s_byte};
  assign port_match  = port_word == dns_port;
  assign name_full   = name_length >= NAME_CAP;

  always_ff @(posedge clk) begin
    if (rst) begin
      dns_port <= 16'd53;
    end else if (cfg_we) begin
      dns_port <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else begin
      s_valid <= in_valid && !in_stall;
    end
    if (in_valid && !in_stall) begin
      s_byte <= pkt_byte;
      s_last <= pkt_last;
    end
  end

  always_comb begin
    byte_offset_next     = byte_offset;
    header_words_next    = header_words;
    src_ip_next          = src_ip;
    dst_ip_next          = dst_ip;
    src_port_hold_next   = src_port_hold;
    udp_length_next      = udp_length;
    packet_counter_next  = packet_counter;
    parse_phase_next     = parse_phase;
    label_remaining_next = label_remaining;
    name_length_next     = name_length;
    port_hit_next        = port_hit;
    res_a                = '0;
    res_b                = '0;
    res_n                = 2'd0;
    if (s_valid) begin
      unique case (parse_phase)
        PH_HEAD: begin
          if (byte_offset != 16'hFFFF) begin
            byte_offset_next = byte_offset + 16'd1;
          end
          priority if (byte_offset == 16'd0) begin
            header_words_next = s_byte[3:0];
            if (s_byte[3:0] < 4'd5) begin
              parse_phase_next = PH_DONE;
            end
          end else if (byte_offset == 16'd9) begin
            if (s_byte != 8'd17) begin
              parse_phase_next = PH_DONE;
            end
          end else if (byte_offset >= 16'd12 && byte_offset <= 16'd15) begin
            src_ip_next = {src_ip[23:0], s_byte};
          end else if (byte_offset >= 16'd16 && byte_offset <= 16'd19) begin
            dst_ip_next = {dst_ip[23:0], s_byte};
          end else if (byte_offset == hdr_len || byte_offset == hdr_len + 16'd2) begin
            src_port_hold_next = {8'd0, s_byte};
          end else if (byte_offset == hdr_len + 16'd1 || byte_offset == hdr_len + 16'd3) begin
            src_port_hold_next = port_word;
            port_hit_next      = port_hit || port_match;
            if (byte_offset == hdr_len + 16'd3 && !(port_hit || port_match)) begin
              parse_phase_next = PH_DONE;
            end
          end else if (byte_offset == hdr_len + 16'd4) begin
            udp_length_next = {s_byte, 8'd0};
          end else if (byte_offset == hdr_len + 16'd5) begin
            udp_length_next = {udp_length[15:8], udp_length[7:0] | s_byte};
          end else if (byte_offset == hdr_len + 16'd7) begin
            packet_counter_next = packet_counter + 32'd1;
            res_a               = make_res(KIND_DETECT, 8'd0, END_ZERO);
            res_n               = 2'd1;
            parse_phase_next    = (udp_length > 16'd20) ? PH_SKIP : PH_DONE;
            byte_offset_next    = 16'd0;
          end else begin
            // hold
          end
        end
        PH_SKIP: begin
          byte_offset_next = offset_inc[15:0];
          if (offset_inc >= 17'd12) begin
            parse_phase_next     = PH_WALK;
            byte_offset_next     = 16'd0;
            label_remaining_next = 8'd0;
            name_length_next     = '0;
          end
        end
        PH_WALK: begin
          if (label_remaining == 8'd0) begin
            priority if (s_byte == 8'd0) begin
              res_a            = make_res(KIND_END, 8'd0, END_ZERO);
              res_n            = 2'd1;
              parse_phase_next = PH_DONE;
            end else if (name_full) begin
              res_a            = make_res(KIND_END, 8'd0, END_CAP);
              res_n            = 2'd1;
              parse_phase_next = PH_DONE;
            end else if (label_reach >= {1'b0, name_span}) begin
              res_a            = make_res(KIND_END, 8'd0, END_PAYLOAD);
              res_n            = 2'd1;
              parse_phase_next = PH_DONE;
            end else begin
              if (name_length != '0) begin
                res_a            = make_res(KIND_CHAR, 8'd46, END_ZERO);
                res_n            = 2'd1;
                name_length_next = name_length + NL_W'(1);
              end
              label_remaining_next = s_byte;
              byte_offset_next     = offset_inc[15:0];
            end
          end else if (name_full) begin
            res_a            = make_res(KIND_END, 8'd0, END_CAP);
            res_n            = 2'd1;
            parse_phase_next = PH_DONE;
          end else begin
            res_a                = make_res(KIND_CHAR, s_byte, END_ZERO);
            res_n                = 2'd1;
            name_length_next     = name_length + NL_W'(1);
            label_remaining_next = label_remaining - 8'd1;
            byte_offset_next     = offset_inc[15:0];
            if (label_remaining == 8'd1 && offset_inc >= {1'b0, name_span}) begin
              res_b            = make_res(KIND_END, 8'd0, END_PAYLOAD);
              res_n            = 2'd2;
              parse_phase_next = PH_DONE;
            end
          end
        end
        default: begin
          // drop
        end
      endcase
      if (s_last) begin
        if (parse_phase_next == PH_SKIP || parse_phase_next == PH_WALK) begin
          if (res_n == 2'd0) begin
            res_a = make_res(KIND_END, 8'd0, END_TRUNC);
          end else begin
            res_b = make_res(KIND_END, 8'd0, END_TRUNC);
          end
          res_n = res_n + 2'd1;
        end
        parse_phase_next     = PH_HEAD;
        byte_offset_next     = 16'd0;
        port_hit_next        = 1'b0;
        label_remaining_next = 8'd0;
        name_length_next     = '0;
      end
      unique case (res_n)
        2'd1:    res_a.run_last = 1'b1;
        2'd2:    res_b.run_last = 1'b1;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset     <= 16'd0;
      header_words    <= 4'd0;
      src_ip          <= 32'd0;
      dst_ip          <= 32'd0;
      src_port_hold   <= 16'd0;
      udp_length      <= 16'd0;
      packet_counter  <= 32'd0;
      parse_phase     <= PH_HEAD;
      label_remaining <= 8'd0;
      name_length     <= '0;
      port_hit        <= 1'b0;
    end else begin
      byte_offset     <= byte_offset_next;
      header_words    <= header_words_next;
      src_ip          <= src_ip_next;
      dst_ip          <= dst_ip_next;
      src_port_hold   <= src_port_hold_next;
      udp_length      <= udp_length_next;
      packet_counter  <= packet_counter_next;
      parse_phase     <= parse_phase_next;
      label_remaining <= label_remaining_next;
      name_length     <= name_length_next;
      port_hit        <= port_hit_next;
    end
  end

  assign oq_pop  = out_valid && !out_stall;
  assign oq_head = oq_mem[oq_rd];

  always_ff @(posedge clk) begin
    if (res_n != 2'd0) begin
      oq_mem[oq_wr] <= '{res: res_a, dns_count: packet_counter_next,
                         source_addr: src_ip_next, dest_addr: dst_ip_next};
    end
    if (res_n == 2'd2) begin
      oq_mem[oq_wr + OQ_AW'(1)] <= '{res: res_b, dns_count: packet_counter_next,
                                     source_addr: src_ip_next, dest_addr: dst_ip_next};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wr    <= '0;
      oq_rd    <= '0;
      oq_count <= '0;
    end else begin
      oq_wr    <= oq_wr + OQ_AW'(res_n);
      oq_rd    <= oq_rd + OQ_AW'(oq_pop);
      oq_count <= oq_count + OQ_CW'(res_n) - OQ_CW'(oq_pop);
    end
  end

  assign out_valid   = oq_count != '0;
  assign result_kind = oq_head.res.kind;
  assign name_char   = oq_head.res.name_char;
  assign end_status  = oq_head.res.end_status;
  assign run_last    = oq_head.res.run_last;
  assign dns_count   = oq_head.dns_count;
  assign source_addr = oq_head.source_addr;
  assign dest_addr   = oq_head.dest_addr;

endmodule

>>> src/dnsqe_checker.sv
// ----------------------------------------------------------------------------
// dnsqe_checker
// Port-level checks on the result channel of the DNS query name extractor.
// ----------------------------------------------------------------------------
module dnsqe_checker
  import dnsqe_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  result_kind,
  input logic [7:0]  name_char,
  input logic [1:0]  end_status,
  input logic [31:0] dns_count,
  input logic        run_last
);

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (result_kind == KIND_DETECT || result_kind == KIND_CHAR ||
                   result_kind == KIND_END))
    else $error("result kind out of range");

  a_char_only: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_kind != KIND_CHAR) |-> name_char == 8'd0)
    else $error("name character set on a non-character result");

  a_status_only: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_kind != KIND_END) |-> end_status == END_ZERO)
    else $error("end status set on a non-end result");

  a_end_closes: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_kind == KIND_END) |-> run_last)
    else $error("end result not last of its byte");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(result_kind) &&
                                  $stable(name_char) && $stable(dns_count)))
    else $error("stalled result changed");

endmodule

bind dns_query_name_extractor_top dnsqe_checker u_dnsqe_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .result_kind (result_kind),
  .name_char   (name_char),
  .end_status  (end_status),
  .dns_count   (dns_count),
  .run_last    (run_last)
);

>>> tb/tb_dns_query_name_extractor_top.sv
// ----------------------------------------------------------------------------
// tb_dns_query_name_extractor_top
// Drives IPv4 packets byte by byte into the DNS query name extractor and
// checks every result against a cycle-free predictor of the header parse,
// port match and query name walk. A short directed set covers short headers,
// other protocols, unmatched ports, truncation at each stage, the payload
// limit and the character cap; random packets follow under three port
// settings and three idling patterns, with one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_dns_query_name_extractor_top;
  import dnsqe_pkg::*;

  localparam int NAME_BUFFER = 256;
  localparam int NAME_CAP = NAME_BUFFER - 1;
  localparam int UDP_PROTO = 17;
  localparam int DNS_HDR_BYTES = 12;
  localparam logic [7:0] DOT_CHAR = 8'h2E;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_CYCLES = 400;
  localparam int ITEM_TARGET = 850;
  localparam int MIN_PHASE_BYTES = 40;

  typedef enum logic [2:0] {PH_HEAD, PH_SKIP, PH_WALK, PH_DONE} parse_phase_e;

  class dns_name_scoreboard;
    logic [15:0]  port_cfg;
    logic [15:0]  offset;
    logic [3:0]   ihl_words;
    logic [7:0]   proto;
    logic [31:0]  saddr;
    logic [31:0]  daddr;
    logic [15:0]  port_acc;
    logic [15:0]  udp_len;
    logic [31:0]  pkt_count;
    parse_phase_e phase;
    logic [7:0]   label_left;
    logic [8:0]   chars;
    bit           hit;
    oq_entry_t    step_q[$];
    oq_entry_t    expected_q[$];
    int           errors;
    int           n_bytes;
    int           n_packets;
    int           n_detect;
    int           n_chars;
    int           n_ends[4];

    function new();
      port_cfg = 16'd53;
      offset = '0;
      ihl_words = '0;
      proto = '0;
      saddr = '0;
      daddr = '0;
      port_acc = '0;
      udp_len = '0;
      pkt_count = '0;
      phase = PH_HEAD;
      label_left = '0;
      chars = '0;
      hit = 1'b0;
      errors = 0;
      n_bytes = 0;
      n_packets = 0;
      n_detect = 0;
      n_chars = 0;
      foreach (n_ends[k]) n_ends[k] = 0;
    endfunction

    function void set_port(logic [15:0] v);
      port_cfg = v;
    endfunction

    function void emit(logic [1:0] kind, logic [7:0] chr, logic [1:0] status);
      oq_entry_t e;
      e.res.kind = kind;
      e.res.name_char = chr;
      e.res.end_status = status;
      e.res.run_last = 1'b0;
      e.dns_count = pkt_count;
      e.source_addr = saddr;
      e.dest_addr = daddr;
      step_q.push_back(e);
      if (kind == KIND_DETECT) n_detect++;
      else if (kind == KIND_CHAR) n_chars++;
      else n_ends[status]++;
    endfunction

    function void header_byte(logic [7:0] b);
      int off;
      int h;
      off = int'(offset);
      h = int'(ihl_words) * 4;
      if (off == 0) begin
        ihl_words = b[3:0];
        if (ihl_words < 4'd5) phase = PH_DONE;
      end else if (off == 9) begin
        proto = b;
        if (int'(b) != UDP_PROTO) phase = PH_DONE;
      end else if (off >= 12 && off <= 15) begin
        saddr = {saddr[23:0], b};
      end else if (off >= 16 && off <= 19) begin
        daddr = {daddr[23:0], b};
      end else if (off == h || off == h + 2) begin
        port_acc = {8'h00, b};
      end else if (off == h + 1 || off == h + 3) begin
        port_acc = {port_acc[7:0], b};
        if (port_acc == port_cfg) hit = 1'b1;
        if (off == h + 3 && !hit) phase = PH_DONE;
      end else if (off == h + 4) begin
        udp_len = {b, 8'h00};
      end else if (off == h + 5) begin
        udp_len[7:0] = b;
      end else if (off == h + 7) begin
        pkt_count = pkt_count + 32'd1;
        emit(KIND_DETECT, 8'h00, END_ZERO);
        phase = (udp_len > 16'd20) ? PH_SKIP : PH_DONE;
        offset = '0;
        return;
      end
      if (offset != 16'hFFFF) offset = offset + 16'd1;
    endfunction

    function void name_byte(logic [7:0] b);
      int i;
      int plen;
      i = int'(offset);
      plen = int'(udp_len) - 20;
      if (label_left == 8'd0) begin
        if (b == 8'd0) begin
          emit(KIND_END, 8'h00, END_ZERO);
          phase = PH_DONE;
        end else if (int'(chars) >= NAME_CAP) begin
          emit(KIND_END, 8'h00, END_CAP);
          phase = PH_DONE;
        end else if (int'(b) + i >= plen) begin
          emit(KIND_END, 8'h00, END_PAYLOAD);
          phase = PH_DONE;
        end else begin
          if (chars != 9'd0) begin
            emit(KIND_CHAR, DOT_CHAR, END_ZERO);
            chars = chars + 9'd1;
          end
          label_left = b;
          offset = 16'(i + 1);
        end
        return;
      end
      if (int'(chars) >= NAME_CAP) begin
        emit(KIND_END, 8'h00, END_CAP);
        phase = PH_DONE;
        return;
      end
      emit(KIND_CHAR, b, END_ZERO);
      chars = chars + 9'd1;
      label_left = label_left - 8'd1;
      i++;
      offset = 16'(i);
      if (label_left == 8'd0 && i >= plen) begin
        emit(KIND_END, 8'h00, END_PAYLOAD);
        phase = PH_DONE;
      end
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      oq_entry_t e;
      step_q.delete();
      n_bytes++;
      case (phase)
        PH_HEAD: header_byte(b);
        PH_SKIP: begin
          offset = offset + 16'd1;
          if (int'(offset) >= DNS_HDR_BYTES) begin
            phase = PH_WALK;
            offset = '0;
            label_left = '0;
            chars = '0;
          end
        end
        PH_WALK: name_byte(b);
        default: ;
      endcase
      if (last) begin
        n_packets++;
        if (phase == PH_SKIP || phase == PH_WALK) emit(KIND_END, 8'h00, END_TRUNC);
        phase = PH_HEAD;
        offset = '0;
        hit = 1'b0;
        label_left = '0;
        chars = '0;
      end
      if (step_q.size() > 0) begin
        e = step_q.pop_back();
        e.res.run_last = 1'b1;
        step_q.push_back(e);
      end
      foreach (step_q[k]) expected_q.push_back(step_q[k]);
    endfunction

    function void compare(string field, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, exp_v, act_v);
      end
    endfunction

    function void check_result(oq_entry_t act);
      oq_entry_t e;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual kind %0d char %0h status %0d",
                 $time, act.res.kind, act.res.name_char, act.res.end_status);
        return;
      end
      e = expected_q.pop_front();
      compare("result_kind", 32'(e.res.kind), 32'(act.res.kind));
      compare("name_char", 32'(e.res.name_char), 32'(act.res.name_char));
      compare("end_status", 32'(e.res.end_status), 32'(act.res.end_status));
      compare("run_last", 32'(e.res.run_last), 32'(act.res.run_last));
      compare("dns_count", e.dns_count, act.dns_count);
      compare("source_addr", e.source_addr, act.source_addr);
      compare("dest_addr", e.dest_addr, act.dest_addr);
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  pkt_byte = '0;
  logic        pkt_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  result_kind;
  logic [7:0]  name_char;
  logic [1:0]  end_status;
  logic [31:0] dns_count;
  logic [31:0] source_addr;
  logic [31:0] dest_addr;
  logic        run_last;

  dns_name_scoreboard sb;
  int unsigned cycle_count = 0;
  int          send_idle = 0;
  int          recv_idle = 0;
  bit          hold_req = 1'b0;
  int          hold_left = 0;
  logic [7:0]  pkt_q[$];
  int          lens_q[$];

  dns_query_name_extractor_top #(
    .NAME_BUFFER(NAME_BUFFER)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .pkt_byte(pkt_byte),
    .pkt_last(pkt_last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .result_kind(result_kind),
    .name_char(name_char),
    .end_status(end_status),
    .dns_count(dns_count),
    .source_addr(source_addr),
    .dest_addr(dest_addr),
    .run_last(run_last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("tb_dns_query_name_extractor_top NOT OK");
    $finish;
  end

  initial begin : result_sink
    oq_entry_t act;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        act.res.kind = result_kind;
        act.res.name_char = name_char;
        act.res.end_status = end_status;
        act.res.run_last = run_last;
        act.dns_count = dns_count;
        act.source_addr = source_addr;
        act.dest_addr = dest_addr;
        sb.check_result(act);
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle);
      end
    end
  end

  task automatic write_port(logic [15:0] v);
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_port(v);
  endtask

  task automatic send_byte(logic [7:0] b, logic last);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pkt_byte <= b;
    pkt_last <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_byte(b, last);
  endtask

  task automatic put_rand(int n);
    repeat (n) pkt_q.push_back(8'($urandom_range(255)));
  endtask

  function automatic int name_len();
    int s;
    s = 0;
    foreach (lens_q[k]) s += lens_q[k] + 1;
    return s;
  endfunction

  task automatic send_pkt(int cut);
    int n;
    n = (cut > 0 && cut < pkt_q.size()) ? cut : pkt_q.size();
    for (int k = 0; k < n; k++) send_byte(pkt_q[k], k == n - 1);
    pkt_q.delete();
  endtask

  task automatic send_query(int ihl, int proto, int sp, int dp, int ulen, int cut);
    pkt_q.push_back({4'h4, 4'(ihl)});
    put_rand(8);
    pkt_q.push_back(8'(proto));
    put_rand(10);
    if (ihl > 5) put_rand((ihl - 5) * 4);
    pkt_q.push_back(8'(sp >> 8));
    pkt_q.push_back(8'(sp));
    pkt_q.push_back(8'(dp >> 8));
    pkt_q.push_back(8'(dp));
    pkt_q.push_back(8'(ulen >> 8));
    pkt_q.push_back(8'(ulen));
    put_rand(2 + DNS_HDR_BYTES);
    foreach (lens_q[k]) begin
      pkt_q.push_back(8'(lens_q[k]));
      put_rand(lens_q[k]);
    end
    pkt_q.push_back(8'h00);
    put_rand(4);
    send_pkt(cut);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_phase(int nbytes);
    int stop_at;
    int r;
    int ihl;
    int proto;
    int sp;
    int dp;
    int ulen;
    int nl;
    int nlab;
    int maxlen;
    int cut;
    stop_at = sb.n_bytes + nbytes;
    while (sb.n_bytes < stop_at) begin
      if ($urandom_range(99) < 8) begin
        put_rand($urandom_range(1, 30));
        send_pkt(0);
      end else begin
        r = $urandom_range(9);
        ihl = (r == 0) ? $urandom_range(15) : (r < 3) ? $urandom_range(6, 15) : 5;
        proto = ($urandom_range(11) == 0) ? $urandom_range(255) : UDP_PROTO;
        case ($urandom_range(9))
          0: begin
            sp = sb.port_cfg;
            dp = $urandom_range(65535);
          end
          1: begin
            sp = sb.port_cfg;
            dp = sb.port_cfg;
          end
          2: begin
            sp = $urandom_range(65535);
            dp = $urandom_range(65535);
          end
          default: begin
            sp = $urandom_range(65535);
            dp = sb.port_cfg;
          end
        endcase
        if ($urandom_range(24) == 0) begin
          nlab = $urandom_range(2, 4);
          maxlen = 140;
        end else begin
          nlab = $urandom_range(0, 4);
          maxlen = 8;
        end
        lens_q.delete();
        repeat (nlab) lens_q.push_back($urandom_range(1, maxlen));
        nl = name_len();
        r = $urandom_range(99);
        if (r < 60) ulen = 25 + nl + $urandom_range(3);
        else if (r < 70) ulen = 20 + nl;
        else if (r < 80) ulen = 20 + $urandom_range(nl);
        else if (r < 90) ulen = $urandom_range(20);
        else ulen = $urandom_range(65535);
        cut = ($urandom_range(7) == 0) ? $urandom_range(1, 70) : 0;
        send_query(ihl, proto, sp, dp, ulen, cut);
      end
    end
  endtask

  initial begin : stimulus
    int third;
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle = 16;
    recv_idle = 46;
    write_port(16'd53);
    lens_q = '{1, 2};
    send_query(5, UDP_PROTO, 16'h1234, 53, 25 + name_len(), 0);
    lens_q.delete();
    send_query(5, UDP_PROTO, 53, 16'hBEEF, 25, 0);
    lens_q = '{4};
    send_query(15, UDP_PROTO, 53, 53, 20, 0);
    send_query(4, UDP_PROTO, 53, 53, 30, 5);
    send_query(5, 6, 53, 53, 30, 12);
    send_query(5, UDP_PROTO, 1000, 2000, 30, 26);
    send_query(5, UDP_PROTO, 7, 53, 30, 10);
    send_query(5, UDP_PROTO, 7, 53, 30, 33);
    lens_q = '{5};
    send_query(5, UDP_PROTO, 53, 9, 30, 43);
    lens_q = '{3, 6};
    send_query(5, UDP_PROTO, 53, 9, 26, 0);
    lens_q = '{3, 2};
    send_query(5, UDP_PROTO, 53, 9, 27, 0);
    lens_q = '{2, 1};
    send_query(5, UDP_PROTO, 9, 53, 65535, 0);
    hold_req = 1'b1;
    lens_q = '{120, 140};
    send_query(5, UDP_PROTO, 53, 9, 25 + name_len(), 0);
    drain();

    third = (ITEM_TARGET - sb.n_bytes) / 3;
    if (third < MIN_PHASE_BYTES) third = MIN_PHASE_BYTES;

    write_port(16'h0000);
    random_phase(third);
    drain();

    send_idle = 46;
    recv_idle = 16;
    write_port(16'hFFFF);
    random_phase(third);
    drain();

    send_idle = 0;
    recv_idle = 0;
    write_port(16'($urandom_range(1, 65534)));
    random_phase(third);
    drain();

    $display("run covered %0d bytes in %0d packets over four port settings and three idling",
             sb.n_bytes, sb.n_packets);
    $display("patterns: %0d detections, %0d characters, ends zero/payload/cap/trunc %0d/%0d/%0d/%0d",
             sb.n_detect, sb.n_chars, sb.n_ends[0], sb.n_ends[1], sb.n_ends[2], sb.n_ends[3]);
    if (sb.errors == 0) begin
      $display("tb_dns_query_name_extractor_top OK");
    end else begin
      $display("tb_dns_query_name_extractor_top NOT OK");
    end
    $finish;
  end

endmodule
